// ===== hw/rtl/nds_pkg.sv =====
// ----------------------------------------------------------------------------
// nds_pkg: shared constants and types for the nearest distance search unit
// Table geometry, field widths and divider geometry used across the design.
// ----------------------------------------------------------------------------
package nds_pkg;

  // Table geometry
  localparam int TABLE_DEPTH    = 4096;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int CNT_W          = ADDR_W + 1;

  // Word field widths
  localparam int DIST_W         = 32;
  localparam int IDX_W          = 12;
  localparam int POS_W          = 10;
  localparam int COUNT_W        = 13;

  // Position scale and target product
  localparam int POSITION_SCALE = 1000;
  localparam int PROD_W         = DIST_W + POS_W;

  // Constant divider: one radix-8 digit per step
  localparam int DIGIT_W        = 3;
  localparam int DIV_STEPS      = (PROD_W + DIGIT_W - 1) / DIGIT_W;
  localparam int QUO_W          = DIV_STEPS * DIGIT_W;
  localparam int REM_W          = $clog2(POSITION_SCALE);
  localparam int VAL_W          = REM_W + DIGIT_W;
  localparam int STEP_W         = $clog2(DIV_STEPS);

  // Function codes of an input word
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_QUERY   = 1'b1;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [IDX_W-1:0]  idx_t;

endpackage

// ===== hw/rtl/nds_channels.sv =====
// ----------------------------------------------------------------------------
// nds_channels: valid/ready channels of the nearest distance search unit
// Item channel (table writes and queries) and result channel.
// ----------------------------------------------------------------------------
interface nds_item_if import nds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  idx_t              entry_index;
  dist_t             entry_distance;
  logic [POS_W-1:0]  position;

  modport source (output valid, func, entry_index, entry_distance, position,
                  input ready);
  modport sink   (input valid, func, entry_index, entry_distance, position,
                  output ready);
endinterface

interface nds_result_if import nds_pkg::*; ();
  logic valid;
  logic ready;
  idx_t nearest_index;
  logic changed;

  modport source (output valid, nearest_index, changed, input ready);
  modport sink   (input valid, nearest_index, changed, output ready);
endinterface

// ===== hw/rtl/nds_ram.sv =====
// ----------------------------------------------------------------------------
// nds_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/nds_div.sv =====
// ----------------------------------------------------------------------------
// nds_div: iterative divider by the position scale
// Long division, one radix-8 digit per cycle; done pulses with the quotient.
// ----------------------------------------------------------------------------
module nds_div import nds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QUO_W-1:0] dividend,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem;
  logic [QUO_W-1:0]  work;
  logic [VAL_W-1:0]  val;
  logic [DIGIT_W-1:0] digit;
  logic [REM_W-1:0]  rem_next;

  // Pick the next quotient digit from the partial remainder
  always_comb begin
    val   = {rem, work[QUO_W-1 -: DIGIT_W]};
    digit = '0;
    for (int k = 1; k < (1 << DIGIT_W); k++) begin
      if (val >= VAL_W'(k * POSITION_SCALE)) begin
        digit = DIGIT_W'(k);
      end
    end
    rem_next = REM_W'(val - VAL_W'(digit) * VAL_W'(POSITION_SCALE));
  end

  // Shift dividend bits out and quotient digits in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        work <= dividend;
      end else if (busy) begin
        rem  <= rem_next;
        work <= {work[QUO_W-DIGIT_W-1:0], digit};
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = work;

endmodule

// ===== hw/rtl/nearest_distance_search_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_distance_search_unit: nearest cumulative-distance lookup
// Holds a distance table, turns a position into a target distance and
// binary-searches the table for the nearest entry.
// ----------------------------------------------------------------------------
// A table write gives no result. A query that finds the table empty goes
// straight to the post. Otherwise, the read of the last entry overlaps the
// accept cycle. Then come ST_MUL and the divider by 1000 (14 radix-8 digits
// and a done pulse). ST_EDGE checks against the first and last entries. Each
// binary-search probe passes through ST_PROBE and ST_TEST (up to 13 probes for
// a full table, each one read of the single table read port). The loop is
// left from ST_PROBE or ST_TEST; ST_FIN_LO, ST_FIN_HI and ST_FIN_CMP compare
// the two neighbours and ST_DONE posts the result. An exact hit or an answer at
// either end of the table skips the rest of the search. The post waits while
// the output register holds a word that is not taken. The item side is ready
// only between queries; a finished result waits in the output register and a
// following write can be taken while it waits.
module nearest_distance_search_unit import nds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [COUNT_W-1:0]   cfg_wr_data,
  nds_item_if.sink             item,
  nds_result_if.source         result
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_EDGE, ST_PROBE, ST_TEST,
    ST_FIN_LO, ST_FIN_HI, ST_FIN_CMP, ST_DONE
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] point_count;
  logic [CNT_W-1:0]   count_q;
  logic [POS_W-1:0]   pos_q;
  dist_t              last_q;
  dist_t              target;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [ADDR_W-1:0]  mid;
  dist_t              diff_lo;
  idx_t               res_idx;
  idx_t               cur_idx;
  logic               out_valid;
  idx_t               out_idx;
  logic               out_changed;

  logic               item_acc;
  logic               out_free;
  logic               post_res;
  logic [CNT_W-1:0]   count_clamp;
  logic [POS_W-1:0]   pos_clamp;
  logic [CNT_W-1:0]   mid_calc;
  logic [CNT_W-1:0]   lo_clamp;
  dist_t              diff_hi;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_raddr;
  dist_t              rd_data;
  logic [PROD_W-1:0]  prod;
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   quotient;

  function automatic dist_t abs_diff(dist_t a, dist_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Handshake and clamped query parameters
  assign item.ready  = (state == ST_IDLE);
  assign item_acc    = item.valid && item.ready;
  assign out_free    = !out_valid || result.ready;
  assign post_res    = (state == ST_DONE) && out_free;
  assign count_clamp = (CNT_W'(point_count) > CNT_W'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : CNT_W'(point_count);
  assign pos_clamp   = (item.position > POS_W'(POSITION_SCALE)) ?
                       POS_W'(POSITION_SCALE) : item.position;

  // Search bounds
  assign mid_calc = lo + ((hi - lo) >> 1);
  assign lo_clamp = (lo >= count_q) ? (count_q - 1'b1) : lo;
  assign diff_hi  = abs_diff(rd_data, target);

  // Table write and read address
  assign ram_we = item_acc && (item.func == FUNC_WRITE) &&
                  (CNT_W'(item.entry_index) < CNT_W'(TABLE_DEPTH));

  always_comb begin
    case (state)
      ST_IDLE:   ram_raddr = ADDR_W'(count_clamp - 1'b1);
      ST_PROBE:  ram_raddr = mid_calc[ADDR_W-1:0];
      ST_FIN_LO: ram_raddr = lo_clamp[ADDR_W-1:0];
      ST_FIN_HI: ram_raddr = hi[ADDR_W-1:0];
      ST_TEST:   ram_raddr = mid;
      default:   ram_raddr = '0;
    endcase
  end

  nds_ram #(
    .WIDTH (DIST_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item.entry_index[ADDR_W-1:0]),
    .wdata (item.entry_distance),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Scale the last entry by the position, then divide by the scale
  assign prod      = PROD_W'(rd_data) * PROD_W'(pos_q);
  assign div_start = (state == ST_MUL);

  nds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (QUO_W'(prod)),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer, held index and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      cur_idx     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        point_count <= cfg_wr_data;
      end
      // Post a finished result, drop a word that was taken
      if (post_res) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_acc && (item.func == FUNC_QUERY)) begin
            count_q <= count_clamp;
            pos_q   <= pos_clamp;
            if (count_clamp == '0) begin
              res_idx <= '0;
              state   <= ST_DONE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          last_q <= rd_data;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            target <= quotient[DIST_W-1:0];
            state  <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          // Clip to the first or last entry before searching
          if (target <= rd_data) begin
            res_idx <= '0;
            state   <= ST_DONE;
          end else if (target >= last_q) begin
            res_idx <= IDX_W'(count_q - 1'b1);
            state   <= ST_DONE;
          end else begin
            lo    <= '0;
            hi    <= count_q - 1'b1;
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (lo <= hi) begin
            mid   <= mid_calc[ADDR_W-1:0];
            state <= ST_TEST;
          end else begin
            state <= ST_FIN_LO;
          end
        end
        ST_TEST: begin
          if (rd_data < target) begin
            lo    <= CNT_W'(mid) + 1'b1;
            state <= ST_PROBE;
          end else if (rd_data > target) begin
            if (mid == '0) begin
              state <= ST_FIN_LO;
            end else begin
              hi    <= CNT_W'(mid) - 1'b1;
              state <= ST_PROBE;
            end
          end else begin
            res_idx <= IDX_W'(mid);
            state   <= ST_DONE;
          end
        end
        ST_FIN_LO: begin
          state <= ST_FIN_HI;
        end
        ST_FIN_HI: begin
          diff_lo <= abs_diff(rd_data, target);
          state   <= ST_FIN_CMP;
        end
        ST_FIN_CMP: begin
          // Lower neighbour wins a tie
          res_idx <= (diff_lo < diff_hi) ? IDX_W'(lo_clamp) : IDX_W'(hi);
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_idx     <= res_idx;
            out_changed <= (res_idx != cur_idx);
            cur_idx     <= res_idx;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.nearest_index = out_idx;
  assign result.changed       = out_changed;

  // The posted result is always the held index
  a_result_matches_held: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.nearest_index == cur_idx))
    else $error("posted index differs from held index");

  // Search window stays inside the table
  a_probe_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> ((lo <= count_q) && (hi < count_q)))
    else $error("search bounds outside the table");

  // Every probed slot is a valid entry
  a_mid_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST) |-> (CNT_W'(mid) < count_q))
    else $error("probe beyond the last entry");

endmodule

// ===== sim/tb_nearest_distance_search_unit.sv =====
// ----------------------------------------------------------------------------
// tb_nearest_distance_search_unit: self-checking bench for the nearest search
// Loads distance tables through the item channel, queries positions against
// them and checks every result word against a built-in predictor or a typed
// expected value. A short directed table runs first, then random phases with
// sorted, linear, flat and shuffled tables. Both channel sides idle at
// random, and one long result hold-off backs the unit up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nearest_distance_search_unit;
  import nds_pkg::*;

  localparam int        DRAIN_CYCLES     = 64;
  localparam int        LONG_HOLD_AT     = 30;
  localparam int        LONG_HOLD_CYCLES = 300;
  // ~450 words at worst gaps, stalls and longest searches, plus the drains
  // around each count write, stay far below this limit
  localparam int        CYCLE_LIMIT      = 1000000;
  localparam int        RANDOM_ITEMS     = 420;
  localparam int        COUNT_MAX        = (1 << COUNT_W) - 1;

  typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_kind_t;
  typedef enum logic [1:0] {FILL_RAMP, FILL_LINEAR, FILL_FLAT, FILL_SHUFFLE} fill_t;

  typedef struct {
    row_kind_t kind;
    logic [31:0] arg_a;
    logic [31:0] arg_b;
    bit          typed;
    idx_t        want_idx;
    logic        want_chg;
  } row_t;

  typedef struct {
    idx_t idx;
    logic changed;
  } answer_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  nds_item_if   item_ch ();
  nds_result_if res_ch ();

  nearest_distance_search_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (res_ch)
  );

  // Predictor state: table copy, point count and held index
  dist_t       dist_tab [TABLE_DEPTH];
  int unsigned active_count;
  idx_t        held_index;
  answer_t     pending_answers[$];
  row_t        dir_rows[$];

  int  err_cnt;
  int  results_seen;
  int  cycle_cnt;
  bit  item_burst;
  bit  ready_burst;

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_nearest_distance_search_unit: done, errors");
      $finish;
    end
  end

  // Binary search for the entry nearest the target, on the first n slots
  function automatic idx_t nearest_slot(longint unsigned target, int n);
    int lo;
    int hi;
    int mid;
    longint unsigned d;
    longint unsigned dl;
    longint unsigned dh;
    lo = 0;
    hi = n - 1;
    if (target <= dist_tab[0]) return idx_t'(0);
    if (target >= dist_tab[hi]) return idx_t'(hi);
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      d = dist_tab[mid];
      if (d < target) begin
        lo = mid + 1;
      end else if (d > target) begin
        if (mid == 0) break;
        hi = mid - 1;
      end else begin
        return idx_t'(mid);
      end
    end
    if (lo >= n) lo = n - 1;
    if (hi >= n) hi = n - 1;
    d  = dist_tab[lo];
    dl = (d >= target) ? d - target : target - d;
    d  = dist_tab[hi];
    dh = (d >= target) ? d - target : target - d;
    // equal distance keeps the slot left in hi
    return (dl < dh) ? idx_t'(lo) : idx_t'(hi);
  endfunction

  // Scale the position to a target, search, and advance the held index
  function automatic answer_t predict_query(logic [POS_W-1:0] pos);
    int unsigned     n;
    longint unsigned scale;
    longint unsigned last;
    idx_t            k;
    answer_t         a;
    n     = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
    scale = (pos > POSITION_SCALE) ? POSITION_SCALE : pos;
    if (n == 0) begin
      k = '0;
    end else begin
      last = dist_tab[n-1];
      k = nearest_slot((last * scale) / POSITION_SCALE, n);
    end
    a.idx     = k;
    a.changed = (k != held_index);
    held_index = k;
    return a;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(row_kind_t kind, logic [31:0] a, logic [31:0] b,
                                  bit typed, idx_t wi, logic wc);
    row_t r;
    r.kind = kind;
    r.arg_a = a;
    r.arg_b = b;
    r.typed = typed;
    r.want_idx = wi;
    r.want_chg = wc;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return '0;
    if (r < 4) return POS_W'(POSITION_SCALE);
    if (r == 4) return POS_W'($urandom_range(POSITION_SCALE + 1, (1 << POS_W) - 1));
    return POS_W'($urandom_range(0, POSITION_SCALE));
  endfunction

  // Positions whose target stops at the first or last entry
  function automatic logic [POS_W-1:0] pick_edge_position();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return '0;
    if (r == 1) return POS_W'(POSITION_SCALE);
    return POS_W'($urandom_range(POSITION_SCALE + 1, (1 << POS_W) - 1));
  endfunction

  // Offer one word after a random gap; hold it until taken, then update the table copy or predict
  task automatic send_word(logic fn, idx_t slot, dist_t dval, logic [POS_W-1:0] pos,
                           bit typed, idx_t want_idx, logic want_chg);
    int      gap;
    answer_t a;
    if ($urandom_range(0, 31) == 0) item_burst = ~item_burst;
    gap = item_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.func           <= fn;
    item_ch.entry_index    <= slot;
    item_ch.entry_distance <= dval;
    item_ch.position       <= pos;
    item_ch.valid          <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    if (fn == FUNC_WRITE) begin
      dist_tab[slot] = dval;
    end else begin
      a = predict_query(pos);
      if (typed) begin
        a.idx     = want_idx;
        a.changed = want_chg;
      end
      pending_answers.insert(pending_answers.size(), a);
    end
  endtask

  // Drain the unit, let it settle, then write the point count
  task automatic set_point_count(int unsigned value);
    item_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(value);
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    active_count  = value;
  endtask

  // Fill slots 0..n-1 in the given pattern
  task automatic load_table(int unsigned n, fill_t style, dist_t top);
    longint unsigned d;
    longint unsigned step;
    longint unsigned flat;
    int unsigned     k;
    d    = $urandom_range(0, top / 8);
    step = (top - d) / n;
    flat = $urandom;
    case ($urandom_range(0, 3))
      0:       k = 1;
      1:       k = 2;
      2:       k = 10;
      default: k = $urandom_range(1, 1000);
    endcase
    for (int unsigned i = 0; i < n; i++) begin
      case (style)
        FILL_RAMP: begin
          send_word(FUNC_WRITE, idx_t'(i), dist_t'(d), POS_W'($urandom), 0, '0, 1'b0);
          d += $urandom_range(0, step);
        end
        FILL_LINEAR:
          send_word(FUNC_WRITE, idx_t'(i), dist_t'(d + i * k), POS_W'($urandom), 0, '0, 1'b0);
        FILL_FLAT:
          send_word(FUNC_WRITE, idx_t'(i), dist_t'(flat), POS_W'($urandom), 0, '0, 1'b0);
        default:
          send_word(FUNC_WRITE, idx_t'(i), dist_t'($urandom), POS_W'($urandom), 0, '0, 1'b0);
      endcase
    end
  endtask

  // Queries with a stray table write now and then
  task automatic run_queries(int nq, bit edges_only, output int sent);
    logic [POS_W-1:0] pos;
    sent = 0;
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_word(FUNC_WRITE, idx_t'($urandom_range(0, TABLE_DEPTH - 1)), dist_t'($urandom),
                  POS_W'($urandom), 0, '0, 1'b0);
        sent++;
      end
      pos = edges_only ? pick_edge_position() : pick_position();
      send_word(FUNC_QUERY, idx_t'($urandom), dist_t'($urandom), pos, 0, '0, 1'b0);
      sent++;
    end
  endtask

  // Result side: random stalls, one long hold-off, check each word
  initial begin : result_sink
    int      stall;
    answer_t want;
    res_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 31) == 0) ready_burst = ~ready_burst;
      stall = ready_burst ? 0 : $urandom_range(0, 8);
      if (results_seen == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      results_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: result word with none expected: nearest_index %0d changed %0b",
                 $time, res_ch.nearest_index, res_ch.changed);
        err_cnt++;
      end else begin
        want = pending_answers.pop_front();
        if (res_ch.nearest_index !== want.idx) begin
          $display("%0t: nearest_index mismatch: expected %0d, actual %0d",
                   $time, want.idx, res_ch.nearest_index);
          err_cnt++;
        end
        if (res_ch.changed !== want.changed) begin
          $display("%0t: changed mismatch: expected %0b, actual %0b",
                   $time, want.changed, res_ch.changed);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, count above depth, random phases, finish
  initial begin : stimulus
    int unsigned n;
    int          sent;
    int          random_items;
    int          phase;
    fill_t       style;
    dist_t       top;
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    item_ch.valid          = 1'b0;
    item_ch.func           = FUNC_WRITE;
    item_ch.entry_index    = '0;
    item_ch.entry_distance = '0;
    item_ch.position       = '0;
    err_cnt      = 0;
    results_seen = 0;
    cycle_cnt    = 0;
    item_burst   = 1'b0;
    ready_burst  = 1'b0;
    active_count = 0;
    held_index   = '0;
    random_items = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table after reset, position clamp
    add_row(ROW_QUERY, 0, 0, 1, 12'd0, 1'b0);
    add_row(ROW_QUERY, 1023, 0, 1, 12'd0, 1'b0);
    // single entry at full scale
    add_row(ROW_CFG, 1, 0, 0, '0, 1'b0);
    add_row(ROW_WRITE, 0, 32'hFFFF_FFFF, 0, '0, 1'b0);
    add_row(ROW_QUERY, 1000, 0, 1, 12'd0, 1'b0);
    // four entries: ends, clamp, exact hit, tie, plain miss
    add_row(ROW_CFG, 4, 0, 0, '0, 1'b0);
    add_row(ROW_WRITE, 0, 100, 0, '0, 1'b0);
    add_row(ROW_WRITE, 1, 200, 0, '0, 1'b0);
    add_row(ROW_WRITE, 2, 300, 0, '0, 1'b0);
    add_row(ROW_WRITE, 3, 400, 0, '0, 1'b0);
    add_row(ROW_QUERY, 1000, 0, 1, 12'd3, 1'b1);
    add_row(ROW_QUERY, 0, 0, 1, 12'd0, 1'b1);
    add_row(ROW_QUERY, 1023, 0, 1, 12'd3, 1'b1);
    add_row(ROW_QUERY, 500, 0, 0, '0, 1'b0);
    add_row(ROW_QUERY, 625, 0, 0, '0, 1'b0);
    add_row(ROW_QUERY, 374, 0, 0, '0, 1'b0);
    // unsorted table, then largest distance as last entry
    add_row(ROW_WRITE, 1, 500, 0, '0, 1'b0);
    add_row(ROW_QUERY, 750, 0, 0, '0, 1'b0);
    add_row(ROW_WRITE, 3, 32'hFFFF_FFFF, 0, '0, 1'b0);
    add_row(ROW_QUERY, 999, 0, 0, '0, 1'b0);
    // top slot written outside the count, then back to an empty table
    add_row(ROW_WRITE, TABLE_DEPTH - 1, 32'hFFFF_FFFF, 0, '0, 1'b0);
    add_row(ROW_QUERY, 1, 0, 0, '0, 1'b0);
    add_row(ROW_CFG, 0, 0, 0, '0, 1'b0);
    add_row(ROW_QUERY, 600, 0, 0, '0, 1'b0);

    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_CFG:
          set_point_count(dir_rows[r].arg_a);
        ROW_WRITE:
          send_word(FUNC_WRITE, idx_t'(dir_rows[r].arg_a), dir_rows[r].arg_b,
                    POS_W'($urandom), 0, '0, 1'b0);
        default:
          send_word(FUNC_QUERY, idx_t'($urandom), dist_t'($urandom),
                    POS_W'(dir_rows[r].arg_a), dir_rows[r].typed,
                    dir_rows[r].want_idx, dir_rows[r].want_chg);
      endcase
    end

    // Count register at its top value reads the top slot as the last entry;
    // the two end slots are written and only edge positions are queried, so every query here stops at an end
    set_point_count(COUNT_MAX);
    send_word(FUNC_WRITE, '0, 32'h4000_0000, POS_W'($urandom), 0, '0, 1'b0);
    send_word(FUNC_WRITE, idx_t'(TABLE_DEPTH - 1), 32'hFFFF_FFFF, POS_W'($urandom),
              0, '0, 1'b0);
    run_queries(20, 1'b1, sent);
    random_items += sent + 2;

    // Random phases, mostly small tables
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0:       n = 2;
        1:       n = 1;
        2:       n = 0;
        default: n = ($urandom_range(0, 9) == 0) ? $urandom_range(TABLE_DEPTH, COUNT_MAX)
                                                 : $urandom_range(3, 48);
      endcase
      set_point_count(n);
      if (n > 0 && n <= 64) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7:  style = FILL_RAMP;
          8, 9, 10, 11, 12, 13, 14: style = FILL_LINEAR;
          15, 16:                   style = FILL_FLAT;
          default:                  style = FILL_SHUFFLE;
        endcase
        top = $urandom_range(0, 1) ? 32'hFFFF_FFFF : dist_t'($urandom_range(16, 5000));
        load_table(n, style, top);
        random_items += n;
      end
      // a count at or above the depth keeps to queries that stop at an end
      run_queries($urandom_range(8, 25), (n > 64), sent);
      random_items += sent;
      phase++;
    end

    // Drain and settle
    item_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_nearest_distance_search_unit: done, clean");
    end else begin
      $display("tb_nearest_distance_search_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/nds_pkg.sv
hw/rtl/nds_channels.sv
hw/rtl/nds_ram.sv
hw/rtl/nds_div.sv
hw/rtl/nearest_distance_search_unit.sv
sim/tb_nearest_distance_search_unit.sv
